FILE: hw/rtl/mtd_pkg.sv
// Shared types and constants for the Morse timing decoder.
// No dependencies; used by morse_timing_decoder_unit.
package mtd_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int DIT_W         = 11;
  localparam int IDX_W         = 7;
  localparam int THR_W         = 14;  // holds 7 * dit unit
  localparam int OUT_TDATA_W   = 16;
  localparam int SLOTS         = 3;

  localparam logic [DIT_W-1:0] DIT_UNIT_RESET = 11'd100;

  // register indexes of the write port
  localparam logic CFG_DIT_UNIT = 1'b0;
  localparam logic CFG_ECHO     = 1'b1;

  // bit k set: tree index k names a defined character
  localparam logic [127:0] DEFINED_MASK =
    {64'h4108200344243030, 64'hD9E7A5DFFFFFFFFC};

  typedef enum logic [2:0] {
    EV_DEF   = 3'd0,
    EV_UNDEF = 3'd1,
    EV_WORD  = 3'd2,
    EV_DIT   = 3'd3,
    EV_DASH  = 3'd4
  } event_t;

  typedef struct packed {
    event_t           event_res;
    logic [IDX_W-1:0] symbol_index;
  } result_t;

endpackage

FILE: hw/rtl/morse_timing_decoder_unit.sv
// Morse timing decoder: key press timing in, tree index events out.
// Uses mtd_pkg for types, constants and the defined-character mask.
// The first result of a beat is on m_* in the cycle after the beat is accepted.
// Throughput: one input beat per cycle while m_tready is high, when it causes at most one result;
//   a beat causing more results holds the input until only its last is left (result queue of 3).
// Reset (rst, synchronous): dit unit 100 ms, echo off, tree index 1,
//   no pending press, result queue empty.
module morse_timing_decoder_unit #(
  parameter int TIME_BITS = mtd_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata: gap_ms [TIME_BITS-1:0], press_ms [2*TIME_BITS-1:TIME_BITS], zero pad
  input  logic [((2*TIME_BITS+7)/8)*8-1:0] s_tdata,
  // s_tuser: kind (0 press, 1 flush)
  input  logic                         s_tuser,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // m_tdata: event_res [2:0], symbol_index [9:3], zero pad [15:10]
  output logic [mtd_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                         m_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [mtd_pkg::DIT_W-1:0]    cfg_data
);

  localparam int CMP_W = (TIME_BITS > mtd_pkg::THR_W) ? TIME_BITS : mtd_pkg::THR_W;

  // configuration, held as precomputed thresholds
  logic [mtd_pkg::THR_W-1:0] three_units;
  logic [mtd_pkg::THR_W-1:0] seven_units;
  logic                      echo_elements;

  // decoder state
  logic [mtd_pkg::IDX_W-1:0] tree_index, tree_index_next;
  logic                      too_long, too_long_next;
  logic                      has_prior_press, has_prior_press_next;

  // result queue, slot 0 is at the output
  mtd_pkg::result_t slots [mtd_pkg::SLOTS];
  mtd_pkg::result_t slots_next [mtd_pkg::SLOTS];
  logic [1:0]       count, count_next;

  logic [TIME_BITS-1:0] gap, press;
  logic [CMP_W-1:0]     gap_ext, press_ext, three_ext, seven_ext;
  logic                 in_beat, out_beat;
  logic                 is_flush, dash, do_close, do_word, do_echo;
  mtd_pkg::result_t     close_res, word_res, echo_res;
  logic [mtd_pkg::IDX_W-1:0] base_index;
  logic                 base_too_long;

  assign gap       = s_tdata[TIME_BITS-1:0];
  assign press     = s_tdata[2*TIME_BITS-1:TIME_BITS];
  assign gap_ext   = CMP_W'(gap);
  assign press_ext = CMP_W'(press);
  assign three_ext = CMP_W'(three_units);
  assign seven_ext = CMP_W'(seven_units);

  assign s_tready = (count == 2'd0) || ((count == 2'd1) && m_tready);
  assign in_beat  = s_tvalid && s_tready;
  assign m_tvalid = (count != 2'd0);
  assign out_beat = m_tvalid && m_tready;
  assign m_tlast  = (count == 2'd1);
  assign m_tdata  = {(mtd_pkg::OUT_TDATA_W - 10)'(0), slots[0].symbol_index,
                     slots[0].event_res};

  always_comb begin
    is_flush = s_tuser;
    dash     = press_ext >= three_ext;

    if (too_long) begin
      close_res.event_res    = mtd_pkg::EV_UNDEF;
      close_res.symbol_index = '0;
    end else begin
      close_res.event_res    = mtd_pkg::DEFINED_MASK[tree_index] ? mtd_pkg::EV_DEF
                                                                 : mtd_pkg::EV_UNDEF;
      close_res.symbol_index = tree_index;
    end
    word_res.event_res    = mtd_pkg::EV_WORD;
    word_res.symbol_index = '0;
    echo_res.event_res    = dash ? mtd_pkg::EV_DASH : mtd_pkg::EV_DIT;
    echo_res.symbol_index = '0;

    if (is_flush) begin
      do_close = (tree_index > mtd_pkg::IDX_W'(1)) || too_long;
      do_word  = 1'b0;
      do_echo  = 1'b0;
    end else begin
      do_close = has_prior_press && (gap_ext >= three_ext);
      do_word  = has_prior_press && (gap_ext >= seven_ext);
      do_echo  = echo_elements;
    end

    // a closed character restarts the tree before this press is added
    base_index    = do_close ? mtd_pkg::IDX_W'(1) : tree_index;
    base_too_long = do_close ? 1'b0 : too_long;

    if (is_flush) begin
      tree_index_next      = mtd_pkg::IDX_W'(1);
      too_long_next        = 1'b0;
      has_prior_press_next = 1'b0;
    end else begin
      tree_index_next      = base_index;
      too_long_next        = base_too_long;
      has_prior_press_next = 1'b1;
      if (!base_too_long) begin
        if (base_index[mtd_pkg::IDX_W-1]) begin
          too_long_next = 1'b1;
        end else begin
          tree_index_next = {base_index[mtd_pkg::IDX_W-2:0], dash};
        end
      end
    end

    // pack the enabled results in order: close, word break, echo
    slots_next[0] = do_close ? close_res : (do_word ? word_res : echo_res);
    slots_next[1] = (do_close && do_word) ? word_res : echo_res;
    slots_next[2] = echo_res;
    count_next    = 2'(do_close) + 2'(do_word) + 2'(do_echo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      three_units     <= mtd_pkg::THR_W'(mtd_pkg::DIT_UNIT_RESET) * mtd_pkg::THR_W'(3);
      seven_units     <= mtd_pkg::THR_W'(mtd_pkg::DIT_UNIT_RESET) * mtd_pkg::THR_W'(7);
      echo_elements   <= 1'b0;
      tree_index      <= mtd_pkg::IDX_W'(1);
      too_long        <= 1'b0;
      has_prior_press <= 1'b0;
      count           <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mtd_pkg::CFG_DIT_UNIT: begin
            three_units <= mtd_pkg::THR_W'(cfg_data) * mtd_pkg::THR_W'(3);
            seven_units <= mtd_pkg::THR_W'(cfg_data) * mtd_pkg::THR_W'(7);
          end
          mtd_pkg::CFG_ECHO: begin
            echo_elements <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (in_beat) begin
        tree_index      <= tree_index_next;
        too_long        <= too_long_next;
        has_prior_press <= has_prior_press_next;
        count           <= count_next;
      end else if (out_beat) begin
        count <= count - 2'd1;
      end
    end
  end

  // queue payload: load on an input beat, else advance on an output beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      slots[0] <= slots_next[0];
      slots[1] <= slots_next[1];
      slots[2] <= slots_next[2];
    end else if (out_beat) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for morse_timing_decoder_unit: random and directed key beats.
// Checks every output beat against an in-bench Morse tree decoder.
// Depends on mtd_pkg and the unit RTL only.
`timescale 1ns / 1ps

module tb_top;
  import mtd_pkg::*;

  localparam int  STALL_LIMIT = 3000;
  localparam int  HOLD_CYCLES = 400;
  localparam int  DRAIN_WAIT  = 4;
  localparam logic KEY_PRESS = 1'b0;
  localparam logic KEY_FLUSH = 1'b1;

  typedef enum int {SPAN_ELEM, SPAN_CHAR, SPAN_WORD} span_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] gap_ms;
    logic [15:0] press_ms;
  } key_t;

  typedef struct packed {
    event_t     ev;
    logic [6:0] sym;
    logic       last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;

  // decoder state and register copies
  logic [10:0] dit_ms = DIT_UNIT_RESET;
  logic        echo_on = 1'b0;
  logic [6:0]  tree_idx = 7'd1;
  logic        tree_too_long = 1'b0;
  logic        prior_press = 1'b0;

  key_t     key_queue[$];
  decoded_t due_events[$];
  int       errors = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  logic     hold_armed = 1'b0;
  int       stall_cycles = 0;

  morse_timing_decoder_unit dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic decoded_t close_symbol();
    decoded_t d;
    d.last = 1'b0;
    if (tree_too_long) begin
      d.ev = EV_UNDEF;
      d.sym = '0;
    end else begin
      d.ev = DEFINED_MASK[tree_idx] ? EV_DEF : EV_UNDEF;
      d.sym = tree_idx;
    end
    tree_idx = 7'd1;
    tree_too_long = 1'b0;
    return d;
  endfunction

  task automatic decode_key(input key_t k);
    decoded_t evs[$];
    decoded_t d;
    int three;
    int seven;
    int nxt;
    logic dash;
    three = int'(dit_ms) * 3;
    seven = int'(dit_ms) * 7;
    if (k.kind == KEY_FLUSH) begin
      if (tree_idx > 7'd1 || tree_too_long) evs.push_back(close_symbol());
      tree_idx = 7'd1;
      tree_too_long = 1'b0;
      prior_press = 1'b0;
    end else begin
      if (prior_press) begin
        if (int'(k.gap_ms) >= three) evs.push_back(close_symbol());
        if (int'(k.gap_ms) >= seven) begin
          d.ev = EV_WORD;
          d.sym = '0;
          d.last = 1'b0;
          evs.push_back(d);
        end
      end
      dash = int'(k.press_ms) >= three;
      if (!tree_too_long) begin
        nxt = int'(tree_idx) * 2 + (dash ? 1 : 0);
        // stop growing once the index would leave the 7-bit tree
        if (nxt > 127) tree_too_long = 1'b1;
        else tree_idx = nxt[6:0];
      end
      if (echo_on) begin
        d.ev = dash ? EV_DASH : EV_DIT;
        d.sym = '0;
        d.last = 1'b0;
        evs.push_back(d);
      end
      prior_press = 1'b1;
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) due_events.push_back(evs[i]);
  endtask

  // key beat driver
  always @(posedge clk) begin : key_driver
    key_t k;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_key({s_tuser, s_tdata[15:0], s_tdata[31:16]});
      if (!s_tvalid || s_tready) begin
        if (key_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          k = key_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= k.kind;
          s_tdata <= {k.press_ms, k.gap_ms};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : event_monitor
    decoded_t want;
    int hold_left;
    logic hold_taken;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      hold_taken = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual event %0d symbol %0d last %0b",
                   $time, m_tdata[2:0], m_tdata[9:3], m_tlast);
        end else begin
          want = due_events.pop_front();
          check_field("event_res", want.ev, m_tdata[2:0]);
          check_field("symbol_index", want.sym, m_tdata[9:3]);
          check_field("last", want.last, m_tlast);
        end
      end
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[10:0];
    if (idx == CFG_DIT_UNIT) dit_ms = value[10:0];
    else echo_on = value[0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // hold until every key is taken and every event seen, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk); while (key_queue.size() != 0 || s_tvalid || due_events.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic add_key(input logic kind, input logic [15:0] gap, input logic [15:0] press);
    key_queue.push_back({kind, gap, press});
  endtask

  function automatic logic [15:0] span_ms(span_e cls);
    int u;
    int lo;
    int hi;
    u = dit_ms;
    if (u == 0) return 16'($urandom_range(65535, 0));
    case (cls)
      SPAN_ELEM: begin lo = 0;     hi = 3 * u - 1; end
      SPAN_CHAR: begin lo = 3 * u; hi = 7 * u - 1; end
      default: begin
        lo = 7 * u;
        hi = ($urandom_range(7) == 0) ? 65535 : 9 * u;
      end
    endcase
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(hi, lo));
  endfunction

  // a threshold value or one below it
  function automatic logic [15:0] near_ms(int mult);
    int v;
    v = mult * int'(dit_ms) - int'($urandom_range(1));
    return (v < 0) ? 16'd0 : 16'(v);
  endfunction

  task automatic add_char(int elems, span_e lead);
    for (int i = 0; i < elems; i++)
      add_key(KEY_PRESS, span_ms(i == 0 ? lead : SPAN_ELEM),
              $urandom_range(1) ? span_ms(SPAN_CHAR) : span_ms(SPAN_ELEM));
  endtask

  task automatic add_random_keys(int n);
    int count;
    int len;
    count = 0;
    while (count < n) begin
      case ($urandom_range(19))
        0: begin
          add_key(KEY_FLUSH, 16'($urandom), 16'($urandom));
          count++;
        end
        1, 2: begin
          add_key(KEY_PRESS, 16'($urandom), 16'($urandom));
          count++;
        end
        3, 4: begin
          add_key(KEY_PRESS, near_ms($urandom_range(1) ? 3 : 7), near_ms(3));
          count++;
        end
        default: begin
          // mostly real characters, now and then one too long for the tree
          len = ($urandom_range(7) == 0) ? $urandom_range(10, 7) : $urandom_range(6, 1);
          add_char(len, ($urandom_range(3) == 0) ? SPAN_WORD : SPAN_CHAR);
          count += len;
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_reg(CFG_DIT_UNIT, 100);
    write_reg(CFG_ECHO, 1);
    tx_idle_pct = 22;
    rx_idle_pct = 85;
    add_key(KEY_FLUSH, 16'hFFFF, 16'hFFFF);
    add_key(KEY_PRESS, 16'd0, 16'd0);
    add_key(KEY_PRESS, 16'hFFFF, 16'hFFFF);
    add_key(KEY_PRESS, 16'd299, 16'd299);
    add_key(KEY_PRESS, 16'd300, 16'd300);
    add_key(KEY_PRESS, 16'd699, 16'd0);
    add_key(KEY_PRESS, 16'd700, 16'd100);
    add_key(KEY_FLUSH, 16'd0, 16'd0);
    // six dashes reach the deepest leaf, a seventh overflows
    repeat (7) add_key(KEY_PRESS, 16'd0, 16'd300);
    add_key(KEY_FLUSH, 16'd0, 16'd0);
    repeat (8) add_key(KEY_PRESS, 16'd0, 16'd300);
    add_key(KEY_PRESS, 16'd700, 16'd100);
    add_key(KEY_FLUSH, 16'd0, 16'd0);
    add_key(KEY_FLUSH, 16'd0, 16'd0);
    wait_drained();

    write_reg(CFG_DIT_UNIT, 1200);
    write_reg(CFG_ECHO, 0);
    add_random_keys(150);
    wait_drained();

    write_reg(CFG_DIT_UNIT, 1);
    write_reg(CFG_ECHO, 1);
    tx_idle_pct = 85;
    rx_idle_pct = 22;
    add_random_keys(110);
    wait_drained();

    write_reg(CFG_DIT_UNIT, 0);
    write_reg(CFG_ECHO, 0);
    add_random_keys(40);
    wait_drained();

    write_reg(CFG_DIT_UNIT, $urandom_range(300, 20));
    write_reg(CFG_ECHO, 1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    add_random_keys(120);
    hold_armed = 1'b1;
    wait_drained();

    write_reg(CFG_DIT_UNIT, 2047);
    add_random_keys(60);
    wait_drained();
    repeat (16) @(negedge clk);

    if (errors == 0 && due_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
